@@ hdl/tlpg_pkg.sv @@
// ============================================================================
// tlpg_pkg - shared definitions for the thick line pixel generator
// Default sizes, command codes and the control/status bundles that join the
// controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps

package tlpg_pkg;

	localparam int COORD_BITS_DEF    = 12;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int MAX_THICKNESS_DEF = 63;
	localparam int THICK_BITS        = 6;
	localparam int COLOR_BITS        = 32;

	// command codes carried in func
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch endpoints, thickness, color
		logic sq_a;        // square |dx|
		logic sq_b;        // square |dy|
		logic sum;         // s = dx^2 + dy^2
		logic perp_clear;  // zero-length line: perpendicular is zero
		logic root_init;   // seed the bit-serial search
		logic root_step;   // one quotient bit
		logic root_sel_y;  // 0: perp_x (m = |dy|), 1: perp_y (m = |dx|)
		logic layer_start; // place the walker at the start of the layer
		logic pix_step;    // emit a pixel and advance
	} tlpg_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic s_zero;
		logic root_last;
		logic layer_end;
		logic line_end;
	} tlpg_sts_t;

endpackage

@@ hdl/tlpg_cmd_if.sv @@
// ============================================================================
// tlpg_cmd_if - command channel of the thick line pixel generator
// Valid/ready channel carrying a line load or a pixel request.
// ============================================================================
`timescale 1ns / 1ps

interface tlpg_cmd_if import tlpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();

	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [COORD_BITS-1:0] x_start;
	logic signed [COORD_BITS-1:0] y_start;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;
	logic        [THICK_BITS-1:0] thickness;
	logic        [COLOR_BITS-1:0] color;

	modport source (
		output valid, func, x_start, y_start, x_end, y_end, thickness, color,
		input  ready
	);

	modport sink (
		input  valid, func, x_start, y_start, x_end, y_end, thickness, color,
		output ready
	);

endinterface

@@ hdl/tlpg_pixel_if.sv @@
// ============================================================================
// tlpg_pixel_if - pixel channel of the thick line pixel generator
// Valid/ready channel carrying one emitted pixel.
// ============================================================================
`timescale 1ns / 1ps

interface tlpg_pixel_if import tlpg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();

	logic                       valid;
	logic                       ready;
	logic signed [COORD_BITS:0] pixel_x;
	logic signed [COORD_BITS:0] pixel_y;
	logic      [COLOR_BITS-1:0] pixel_color;
	logic                       last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);

endinterface

@@ hdl/tlpg_ctrl.sv @@
// ============================================================================
// tlpg_ctrl - controller of the thick line pixel generator
// Sequences the load setup (squares, two bit-serial root/divide searches,
// layer placement) and runs the pixel handshake with its output valid flag.
// ============================================================================
`timescale 1ns / 1ps

module tlpg_ctrl import tlpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_func,
	output logic      cmd_ready,
	output logic      pix_valid,
	input  logic      pix_ready,
	input  tlpg_sts_t sts,
	output tlpg_ctl_t ctl
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_A,
		ST_SQ_B,
		ST_SUM,
		ST_ROOT_X_INIT,
		ST_ROOT_X,
		ST_ROOT_Y_INIT,
		ST_ROOT_Y,
		ST_LAYER,
		ST_RUN
	} state_t;

	state_t state_q, state_d;
	logic   pix_valid_q;
	logic   slot_free;
	logic   take;

	always_comb begin
		slot_free = !pix_valid_q || pix_ready;
		cmd_ready = ((state_q == ST_IDLE) || (state_q == ST_RUN)) && slot_free;
		take      = cmd_valid && cmd_ready;
		ctl       = '0;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				// a pixel request with no line is taken and dropped
				if (take && (cmd_func == FUNC_LOAD)) begin
					ctl.load = 1'b1;
					state_d  = ST_SQ_A;
				end
			end
			ST_SQ_A: begin
				ctl.sq_a = 1'b1;
				state_d  = ST_SQ_B;
			end
			ST_SQ_B: begin
				ctl.sq_b = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum = 1'b1;
				state_d = ST_ROOT_X_INIT;
			end
			ST_ROOT_X_INIT: begin
				if (sts.s_zero) begin
					ctl.perp_clear = 1'b1;
					state_d        = ST_LAYER;
				end else begin
					ctl.root_init = 1'b1;
					state_d       = ST_ROOT_X;
				end
			end
			ST_ROOT_X: begin
				ctl.root_step = 1'b1;
				if (sts.root_last) begin
					state_d = ST_ROOT_Y_INIT;
				end
			end
			ST_ROOT_Y_INIT: begin
				ctl.root_init  = 1'b1;
				ctl.root_sel_y = 1'b1;
				state_d        = ST_ROOT_Y;
			end
			ST_ROOT_Y: begin
				ctl.root_step  = 1'b1;
				ctl.root_sel_y = 1'b1;
				if (sts.root_last) begin
					state_d = ST_LAYER;
				end
			end
			ST_LAYER: begin
				ctl.layer_start = 1'b1;
				state_d         = ST_RUN;
			end
			ST_RUN: begin
				if (take) begin
					if (cmd_func == FUNC_LOAD) begin
						ctl.load = 1'b1;
						state_d  = ST_SQ_A;
					end else begin
						ctl.pix_step = 1'b1;
						if (sts.layer_end) begin
							state_d = sts.line_end ? ST_IDLE : ST_LAYER;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.pix_step) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign pix_valid = pix_valid_q;

endmodule

@@ hdl/tlpg_datapath.sv @@
// ============================================================================
// tlpg_datapath - datapath of the thick line pixel generator
// Line registers, shared squarer, bit-serial unit-perpendicular search,
// layer offset and the Bresenham walker with its output register.
// ============================================================================
`timescale 1ns / 1ps

module tlpg_datapath import tlpg_pkg::*; #(
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
) (
	input  logic                         clk,
	input  tlpg_ctl_t                    ctl,
	output tlpg_sts_t                    sts,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic        [THICK_BITS-1:0] thickness,
	input  logic        [COLOR_BITS-1:0] color,
	output logic signed   [COORD_BITS:0] pixel_x,
	output logic signed   [COORD_BITS:0] pixel_y,
	output logic        [COLOR_BITS-1:0] pixel_color,
	output logic                         last_pixel
);

	localparam int CW       = COORD_BITS;
	localparam int DW       = CW + 1;                    // deltas and output coords
	localparam int SQW      = 2 * CW;                    // one square
	localparam int SW       = 2 * CW + 1;                // sum of squares
	localparam int RW       = 2 * CW + 2 * FRAC_BITS + 8; // search residue
	localparam int QW       = FRAC_BITS + 1;             // magnitude, up to 1.0
	localparam int PW       = FRAC_BITS + 2;             // signed perpendicular
	localparam int HALF_MAX = MAX_THICKNESS / 2;
	localparam int HTW      = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
	localparam int LW       = HTW + 1;                   // signed layer index
	localparam int MW       = PW + LW;                   // perp * layer
	localparam int RSH_S    = 2 * FRAC_BITS + 2;
	localparam int RSH_P    = FRAC_BITS + 2;

	// line registers
	logic signed [CW-1:0]  base_x_q, base_y_q;
	logic signed [DW-1:0]  delta_x_q, delta_y_q;
	logic        [HTW-1:0] half_q;
	logic signed [LW-1:0]  layer_q;
	logic [COLOR_BITS-1:0] color_q;
	logic signed [PW-1:0]  perp_x_q, perp_y_q;

	// setup
	logic [SQW-1:0]       sqa_q, sqb_q;
	logic [SW-1:0]        s_q;
	logic signed [RW-1:0] r_q, a_q, b_q;
	logic [QW-1:0]        q_q, mask_q;

	// walker
	logic signed [DW-1:0] cur_x_q, cur_y_q;
	logic [CW-1:0]        err_q, step_q;

	// output register
	logic signed [DW-1:0]  pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0] pix_color_q;
	logic                  pix_last_q;

	// combinational
	logic [HTW-1:0]       half_d;
	logic [DW-1:0]        ndx, ndy;
	logic [CW-1:0]        adx, ady, major, minor, mul_in;
	logic [SQW-1:0]       sq_prod, m2;
	logic                 x_major;
	logic signed [RW-1:0] r_try;
	logic                 take;
	logic [QW-1:0]        q_new;
	logic [CW:0]          err_sum;
	logic                 err_hit;
	logic [CW:0]          err_next;
	logic                 layer_end, line_end;
	logic signed [DW-1:0] step_x, step_y;

	// (p * i) >> FRAC_BITS, truncated toward zero
	function automatic logic signed [DW-1:0] offset_of(
		input logic signed [PW-1:0] p,
		input logic signed [LW-1:0] i
	);
		logic signed [MW-1:0] prod;
		logic        [MW-1:0] mag;
		logic        [MW-1:0] shr;
		logic signed [MW-1:0] off;
		prod = MW'(p) * MW'(i);
		mag  = prod[MW-1] ? MW'(-prod) : MW'(prod);
		shr  = mag >> FRAC_BITS;
		off  = prod[MW-1] ? -$signed(shr) : $signed(shr);
		return DW'(off);
	endfunction

	always_comb begin
		int unsigned tsat;
		tsat = 32'(thickness);
		if (tsat > 32'(MAX_THICKNESS)) begin
			tsat = 32'(MAX_THICKNESS);
		end
		half_d = HTW'(tsat >> 1);
	end

	assign ndx = -delta_x_q;
	assign ndy = -delta_y_q;
	assign adx = delta_x_q[DW-1] ? ndx[CW-1:0] : delta_x_q[CW-1:0];
	assign ady = delta_y_q[DW-1] ? ndy[CW-1:0] : delta_y_q[CW-1:0];

	// shared squarer
	assign mul_in  = ctl.sq_b ? ady : adx;
	assign sq_prod = SQW'(mul_in) * SQW'(mul_in);

	// search step: accept the bit if (2c-1)^2 * s stays within m^2 * 4^(F+1)
	assign m2    = ctl.root_sel_y ? sqa_q : sqb_q;
	assign r_try = r_q - a_q - b_q;
	assign take  = !r_try[RW-1] && !q_q[QW-1];
	assign q_new = take ? (q_q | mask_q) : q_q;

	// Bresenham
	assign x_major   = adx > ady;
	assign major     = x_major ? adx : ady;
	assign minor     = x_major ? ady : adx;
	assign layer_end = step_q == major;
	assign line_end  = layer_q == $signed({1'b0, half_q});
	assign err_sum   = (CW + 1)'(err_q) + (CW + 1)'(minor);
	assign err_hit   = err_sum >= (CW + 1)'(major);
	assign err_next  = err_hit ? (err_sum - (CW + 1)'(major)) : err_sum;
	assign step_x    = (!delta_x_q[DW-1] && (delta_x_q != '0)) ? DW'(1) : -DW'(1);
	assign step_y    = (!delta_y_q[DW-1] && (delta_y_q != '0)) ? DW'(1) : -DW'(1);

	always_comb begin
		sts.s_zero    = s_q == '0;
		sts.root_last = mask_q[0];
		sts.layer_end = layer_end;
		sts.line_end  = line_end;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			base_x_q  <= x_start;
			base_y_q  <= y_start;
			delta_x_q <= $signed({x_end[CW-1], x_end}) - $signed({x_start[CW-1], x_start});
			delta_y_q <= $signed({y_end[CW-1], y_end}) - $signed({y_start[CW-1], y_start});
			half_q    <= half_d;
			layer_q   <= LW'(0) - $signed({1'b0, half_d});
			color_q   <= color;
		end

		if (ctl.sq_a) begin
			sqa_q <= sq_prod;
		end
		if (ctl.sq_b) begin
			sqb_q <= sq_prod;
		end
		if (ctl.sum) begin
			s_q <= SW'(sqa_q) + SW'(sqb_q);
		end

		if (ctl.perp_clear) begin
			perp_x_q <= '0;
			perp_y_q <= '0;
		end

		if (ctl.root_init) begin
			r_q    <= (RW'(m2) << RSH_S) - RW'(s_q);
			a_q    <= -(RW'(s_q) << RSH_P);
			b_q    <= RW'(s_q) << RSH_S;
			q_q    <= '0;
			mask_q <= {1'b1, {FRAC_BITS{1'b0}}};
		end else if (ctl.root_step) begin
			if (take) begin
				r_q <= r_try;
			end
			a_q    <= (a_q >>> 1) + (take ? b_q : RW'(0));
			b_q    <= b_q >>> 2;
			q_q    <= q_new;
			mask_q <= mask_q >> 1;
			if (mask_q[0]) begin
				if (ctl.root_sel_y) begin
					perp_y_q <= delta_x_q[DW-1] ? -$signed(PW'(q_new)) : $signed(PW'(q_new));
				end else begin
					perp_x_q <= (!delta_y_q[DW-1] && (delta_y_q != '0)) ?
						-$signed(PW'(q_new)) : $signed(PW'(q_new));
				end
			end
		end

		if (ctl.layer_start) begin
			cur_x_q <= DW'(base_x_q) + offset_of(perp_x_q, layer_q);
			cur_y_q <= DW'(base_y_q) + offset_of(perp_y_q, layer_q);
			err_q   <= '0;
			step_q  <= '0;
		end else if (ctl.pix_step) begin
			pix_x_q     <= cur_x_q;
			pix_y_q     <= cur_y_q;
			pix_color_q <= color_q;
			pix_last_q  <= layer_end && line_end;
			if (layer_end) begin
				if (!line_end) begin
					layer_q <= layer_q + LW'(1);
				end
			end else begin
				err_q  <= err_next[CW-1:0];
				step_q <= step_q + CW'(1);
				if (x_major) begin
					cur_x_q <= cur_x_q + step_x;
					if (err_hit) begin
						cur_y_q <= cur_y_q + step_y;
					end
				end else begin
					cur_y_q <= cur_y_q + step_y;
					if (err_hit) begin
						cur_x_q <= cur_x_q + step_x;
					end
				end
			end
		end
	end

	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = pix_last_q;

endmodule

@@ hdl/thick_line_pixel_generator.sv @@
// ============================================================================
// thick_line_pixel_generator - thick line rasterizer, one pixel per request
// A load transaction (func = 0) latches two endpoints, a thickness (clamped
// to MAX_THICKNESS) and a color, and replaces any line in progress. The block
// then forms the unit perpendicular (-dy/len, dx/len) as signed Q1.FRAC_BITS
// values rounded to nearest, with a bit-serial root-and-divide search that
// resolves one quotient bit per cycle, first for x and then for y. A load
// holds cmd.ready low through the squares, the sum, both searches and the
// layer placement (a zero-length line skips the searches). The line is drawn
// as layers -(t/2) .. t/2, each a Bresenham walk of max(|dx|,|dy|)+1 pixels
// from the first endpoint shifted by perp*layer (truncated toward zero).
// Each request transaction (func = 1) yields exactly one pixel transaction;
// within a layer requests are taken every cycle unless the pixel output
// stalls, and each new layer passes through a placement state for the offset
// multiply. last_pixel marks the final pixel of the final layer, after which
// the block goes idle; requests with no line in progress are taken and
// produce nothing. The pixel output is registered, so a request is taken
// while the previous pixel waits if that pixel is taken in the same cycle.
// ============================================================================
`timescale 1ns / 1ps

module thick_line_pixel_generator import tlpg_pkg::*; #(
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int MAX_THICKNESS = MAX_THICKNESS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tlpg_cmd_if.sink    cmd,
	tlpg_pixel_if.source pixel
);

	tlpg_ctl_t ctl;   // controller commands
	tlpg_sts_t sts;   // datapath status

	// Controller: setup sequence, line/idle state and the pixel valid flag.
	tlpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_func  (cmd.func),
		.cmd_ready (cmd.ready),
		.pix_valid (pixel.valid),
		.pix_ready (pixel.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: line registers, squarer, perpendicular search, walker and
	// the pixel payload register.
	tlpg_datapath #(
		.COORD_BITS    (COORD_BITS),
		.FRAC_BITS     (FRAC_BITS),
		.MAX_THICKNESS (MAX_THICKNESS)
	) u_datapath (
		.clk         (clk),
		.ctl         (ctl),
		.sts         (sts),
		.x_start     (cmd.x_start),
		.y_start     (cmd.y_start),
		.x_end       (cmd.x_end),
		.y_end       (cmd.y_end),
		.thickness   (cmd.thickness),
		.color       (cmd.color),
		.pixel_x     (pixel.pixel_x),
		.pixel_y     (pixel.pixel_y),
		.pixel_color (pixel.pixel_color),
		.last_pixel  (pixel.last_pixel)
	);

`ifndef SYNTH
	// a new pixel never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pix_step |-> (!pixel.valid || pixel.ready))
		else $error("pixel register overwritten while holding a pixel");

	// a load always starts the setup sequence, which blocks the command side
	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && (cmd.func == FUNC_LOAD)) |=> !cmd.ready)
		else $error("command taken right after a load transaction");

	// every new pixel comes from a request transaction in the cycle before
	a_pixel_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pixel.valid) |-> $past(cmd.valid && cmd.ready && (cmd.func == FUNC_STEP)))
		else $error("pixel emitted without a request transaction");

	// setup commands never overlap pixel emission
	a_setup_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.root_init || ctl.root_step || ctl.layer_start) |-> !ctl.pix_step && !cmd.ready)
		else $error("pixel request taken during setup");
`endif

endmodule
